[rtl/pf_pkg.sv]
`timescale 1ns / 1ps

package pf_pkg;

  // Command codes carried on the input tuser field
  typedef enum logic [2:0] {
    OP_KEY_RESET   = 3'd0,
    OP_KEY_LETTER  = 3'd1,
    OP_KEY_FINISH  = 3'd2,
    OP_TEXT_LETTER = 3'd3,
    OP_TEXT_END    = 3'd4
  } pf_op_t;

  localparam int OpW     = 3;
  localparam int CharW   = 8;
  localparam int LetterW = 5;
  localparam int CellW   = 5;
  localparam int OutW    = 7;
  localparam int Letters = 26;
  localparam int Cells   = 25;

  // Controller to datapath
  typedef struct packed {
    logic latch;        // capture the accepted item
    logic clear;        // key reset
    logic place;        // place the key letter of the held item
    logic walk_start;   // restart the key finish letter counter
    logic walk_step;    // place the counter letter and advance
    logic set_pend;     // hold the text letter as pending
    logic drop_pend;    // pending letter is consumed by this pair
    logic pair_rd;      // look up the positions of the pair
    logic pair_with_x;  // second letter of the pair is x
    logic sq_rd;        // look up the two cipher cells
    logic out_load;     // load the result register
  } pf_ctl_t;

  // Datapath to controller
  typedef struct packed {
    pf_op_t op;
    logic   lower;      // held byte is a lower-case letter
    logic   is_q;
    logic   pend_valid;
    logic   pend_equal; // held letter repeats the pending one
    logic   walk_last;
    logic   out_free;
  } pf_stat_t;

endpackage

[rtl/pf_ram.sv]
`timescale 1ns / 1ps

module pf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/pf_ctrl.sv]
`timescale 1ns / 1ps

module pf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  pf_pkg::pf_stat_t  stat,
  output pf_pkg::pf_ctl_t   ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_WALK,
    S_POS,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (stat.op)
          pf_pkg::OP_KEY_RESET: begin
            ctl.clear = 1'b1;
          end
          pf_pkg::OP_KEY_LETTER: begin
            ctl.place = stat.lower;
          end
          pf_pkg::OP_KEY_FINISH: begin
            ctl.walk_start = 1'b1;
            state_nxt      = S_WALK;
          end
          pf_pkg::OP_TEXT_LETTER: begin
            if (stat.lower && !stat.is_q) begin
              if (!stat.pend_valid) begin
                ctl.set_pend = 1'b1;
              end else begin
                // a doubled letter pairs with x and stays pending
                ctl.pair_rd     = 1'b1;
                ctl.pair_with_x = stat.pend_equal;
                ctl.drop_pend   = !stat.pend_equal;
                state_nxt       = S_POS;
              end
            end
          end
          pf_pkg::OP_TEXT_END: begin
            if (stat.pend_valid) begin
              ctl.pair_rd     = 1'b1;
              ctl.pair_with_x = 1'b1;
              ctl.drop_pend   = 1'b1;
              state_nxt       = S_POS;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_WALK: begin
        ctl.walk_step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_POS: begin
        ctl.sq_rd = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Lookups and key walk never overlap an accepted item
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.latch |=> !in_tready)
    else $error("item accepted while busy");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.walk_step && stat.walk_last) |=> (state_r == S_IDLE))
    else $error("key walk did not finish");

  a_pos_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pair_rd |=> ctl.sq_rd)
    else $error("cell lookup did not follow position lookup");

endmodule

[rtl/pf_dp.sv]
`timescale 1ns / 1ps

module pf_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [pf_pkg::CharW-1:0]           in_char,
  input  logic [pf_pkg::OpW-1:0]             in_cmd,
  input  logic                               out_tready,
  input  pf_pkg::pf_ctl_t                    ctl,
  output pf_pkg::pf_stat_t                   stat,
  output logic                               out_valid,
  output logic [pf_pkg::OutW-1:0]            out_first,
  output logic [pf_pkg::OutW-1:0]            out_second
);

  localparam logic [pf_pkg::LetterW-1:0] IdxQ       = 5'd16;
  localparam logic [pf_pkg::LetterW-1:0] IdxX       = 5'd23;
  localparam logic [pf_pkg::LetterW-1:0] LastLetter = 5'(pf_pkg::Letters - 1);
  localparam logic [pf_pkg::CellW-1:0]   CellCount  = 5'(pf_pkg::Cells);
  localparam logic [pf_pkg::CharW-1:0]   LowerA     = 8'd97;
  localparam logic [pf_pkg::CharW-1:0]   LowerZ     = 8'd122;
  localparam logic [pf_pkg::OutW-1:0]    UpperA     = 7'd65;

  // Row of a cell: cell / 5 for cells 0..24
  function automatic logic [2:0] cell_row(input logic [4:0] c);
    logic [2:0] r;
    if (c < 5'd5) begin
      r = 3'd0;
    end else if (c < 5'd10) begin
      r = 3'd1;
    end else if (c < 5'd15) begin
      r = 3'd2;
    end else if (c < 5'd20) begin
      r = 3'd3;
    end else begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == 3'd4) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  logic [pf_pkg::OpW-1:0]     op_r;
  logic [pf_pkg::CharW-1:0]   char_r;
  logic [pf_pkg::Letters-1:0] letter_used_r;
  logic [pf_pkg::CellW-1:0]   fill_count_r;
  logic [pf_pkg::LetterW-1:0] walk_cnt_r;
  logic                       pend_valid_r;
  logic [pf_pkg::LetterW-1:0] pend_letter_r;
  logic                       pa_vld_r, pb_vld_r;
  logic [pf_pkg::CellW-1:0]   xaddr_r, yaddr_r;
  logic                       out_valid_r;
  logic [pf_pkg::OutW-1:0]    first_r, second_r;

  logic                       lower;
  logic [pf_pkg::LetterW-1:0] idx;
  logic [pf_pkg::LetterW-1:0] pl_letter;
  logic                       pl_en;
  logic [pf_pkg::LetterW-1:0] pair_b;
  logic [pf_pkg::CellW-1:0]   pos_a_raw, pos_b_raw, pos_a, pos_b;
  logic [2:0]                 ra, ca, rb, cb;
  logic [pf_pkg::CellW-1:0]   x_cmb, y_cmb, sq_raddr_a, sq_raddr_b;
  logic [pf_pkg::LetterW-1:0] sq_a_raw, sq_b_raw, sq_a, sq_b;

  assign lower = (char_r >= LowerA) && (char_r <= LowerZ);
  assign idx   = lower ? 5'(char_r - LowerA) : '0;

  assign pl_letter = ctl.walk_step ? walk_cnt_r : idx;
  assign pl_en     = (ctl.place || ctl.walk_step) && (pl_letter != IdxQ) &&
                     (fill_count_r < CellCount) && !letter_used_r[pl_letter];

  assign pair_b = ctl.pair_with_x ? IdxX : idx;

  // position_of: letter -> cell; letter_used marks written entries
  pf_ram #(.WIDTH(pf_pkg::CellW), .DEPTH(pf_pkg::Letters)) u_pos_ram (
    .clk     (clk),
    .we      (pl_en),
    .waddr   (pl_letter),
    .wdata   (fill_count_r),
    .raddr_a (pend_letter_r),
    .raddr_b (pair_b),
    .rdata_a (pos_a_raw),
    .rdata_b (pos_b_raw)
  );

  assign pos_a = pa_vld_r ? pos_a_raw : '0;
  assign pos_b = pb_vld_r ? pos_b_raw : '0;

  always_comb begin
    ra = cell_row(pos_a);
    rb = cell_row(pos_b);
    ca = 3'(pos_a - cell_at(ra, 3'd0));
    cb = 3'(pos_b - cell_at(rb, 3'd0));
    if (ra == rb) begin
      x_cmb = cell_at(ra, wrap_inc(ca));
      y_cmb = cell_at(ra, wrap_inc(cb));
    end else if (ca == cb) begin
      x_cmb = cell_at(wrap_inc(ra), ca);
      y_cmb = cell_at(wrap_inc(rb), ca);
    end else begin
      x_cmb = cell_at(ra, cb);
      y_cmb = cell_at(rb, ca);
    end
  end

  assign sq_raddr_a = ctl.sq_rd ? x_cmb : xaddr_r;
  assign sq_raddr_b = ctl.sq_rd ? y_cmb : yaddr_r;

  // square: cell -> letter; cells below fill_count are written
  pf_ram #(.WIDTH(pf_pkg::LetterW), .DEPTH(pf_pkg::Cells)) u_sq_ram (
    .clk     (clk),
    .we      (pl_en),
    .waddr   (fill_count_r),
    .wdata   (pl_letter),
    .raddr_a (sq_raddr_a),
    .raddr_b (sq_raddr_b),
    .rdata_a (sq_a_raw),
    .rdata_b (sq_b_raw)
  );

  assign sq_a = (xaddr_r < fill_count_r) ? sq_a_raw : '0;
  assign sq_b = (yaddr_r < fill_count_r) ? sq_b_raw : '0;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      op_r   <= in_cmd;
      char_r <= in_char;
    end
    if (ctl.pair_rd) begin
      pa_vld_r <= letter_used_r[pend_letter_r];
      pb_vld_r <= letter_used_r[pair_b];
    end
    if (ctl.sq_rd) begin
      xaddr_r <= x_cmb;
      yaddr_r <= y_cmb;
    end
    if (ctl.out_load) begin
      first_r  <= 7'(sq_a) + UpperA;
      second_r <= 7'(sq_b) + UpperA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      letter_used_r <= '0;
      fill_count_r  <= '0;
      walk_cnt_r    <= '0;
      pend_valid_r  <= 1'b0;
      pend_letter_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (ctl.clear) begin
        letter_used_r <= '0;
        fill_count_r  <= '0;
        pend_valid_r  <= 1'b0;
        pend_letter_r <= '0;
      end else begin
        if (pl_en) begin
          letter_used_r[pl_letter] <= 1'b1;
          fill_count_r             <= fill_count_r + 5'd1;
        end
        if (ctl.set_pend) begin
          pend_valid_r  <= 1'b1;
          pend_letter_r <= idx;
        end else if (ctl.drop_pend) begin
          pend_valid_r <= 1'b0;
        end
      end
      if (ctl.walk_start) begin
        walk_cnt_r <= '0;
      end else if (ctl.walk_step && (walk_cnt_r != LastLetter)) begin
        walk_cnt_r <= walk_cnt_r + 5'd1;
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.op         = pf_pkg::pf_op_t'(op_r);
    stat.lower      = lower;
    stat.is_q       = (idx == IdxQ);
    stat.pend_valid = pend_valid_r;
    stat.pend_equal = (pend_letter_r == idx);
    stat.walk_last  = (walk_cnt_r == LastLetter);
    stat.out_free   = !out_valid_r || out_tready;
  end

  assign out_valid  = out_valid_r;
  assign out_first  = first_r;
  assign out_second = second_r;

  a_fill_matches_used: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(letter_used_r) == 32'(fill_count_r))
    else $error("fill count out of step with placed letters");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_count_r <= CellCount)
    else $error("square overfilled");

  a_q_never_placed: assert property (@(posedge clk) disable iff (!rst_n)
    !letter_used_r[IdxQ])
    else $error("letter q placed in the square");

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

endmodule

[rtl/playfair_encrypt_stream.sv]
`timescale 1ns / 1ps

// Playfair encryption over a byte stream, 5x5 square without the letter q.
// Input channel (in_*): tuser carries the command (key reset, key letter,
// key finish, text letter, text end), tdata the raw ASCII byte. Bytes that
// are not lower-case letters are dropped; a text q is dropped too.
// Result channel (out_*): one transfer per coded pair, two upper-case ASCII
// letters. A key letter or key reset occupies the block from acceptance
// through its dispatch step, a key finish also through a walk over the
// alphabet through the single write port of the square and position memories.
// A text item that completes a pair passes dispatch, position lookup, cell
// lookup and result load; other text items end after dispatch.
// The result register parts the two sides: the next item is accepted while
// a result waits; only a new pair stalls in its load step until the
// receiver takes the previous one. Synchronous reset (rst_n low) empties
// the square, drops any pending letter and clears the result valid flag.
module playfair_encrypt_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [6:0] first_out, [13:7] second_out, [15:14] zero
);

  pf_pkg::pf_ctl_t  ctl;
  pf_pkg::pf_stat_t stat;
  logic [pf_pkg::OutW-1:0] first_out, second_out;

  // Sequencer: accept, dispatch, key walk, lookups, result load
  pf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Square, letter positions, pending letter and result register
  pf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_char    (in_tdata),
    .in_cmd     (in_tuser),
    .out_tready (out_tready),
    .ctl        (ctl),
    .stat       (stat),
    .out_valid  (out_tvalid),
    .out_first  (first_out),
    .out_second (second_out)
  );

  assign out_tdata = {2'b00, second_out, first_out};

endmodule
